// ===== sv/lap5_pkg.sv =====
// Shared types, widths and helpers for the five-point Laplacian stencil core.
// Used by lap5_row_store and five_point_laplacian_stencil_core.
// No dependencies.
package lap5_pkg;

	localparam int MAX_SIDE    = 1024;
	localparam int IDX_W       = $clog2(MAX_SIDE);
	localparam int SIDE_W      = IDX_W + 1;
	localparam int SMP_W       = 32;
	localparam int RES_W       = 35;
	localparam int SIDE_RESET  = 15;
	localparam int OUT_TDATA_W = ((RES_W + 2 * IDX_W + 7) / 8) * 8;
	localparam int OUT_PAD_W   = OUT_TDATA_W - RES_W - 2 * IDX_W;

	typedef logic        [IDX_W-1:0] idx_t;
	typedef logic signed [SMP_W-1:0] smp_t;
	typedef logic signed [RES_W-1:0] res_t;

	// one row-store entry: the two most recent rows at one column
	typedef struct packed {
		smp_t older;
		smp_t prev;
	} pair_t;

	typedef struct packed {
		logic  en;
		idx_t  addr;
		pair_t data;
	} ram_wr_t;

	typedef struct packed {
		logic fin;
		idx_t column;
		idx_t row;
		res_t result;
	} slot_t;

	function automatic res_t sx(smp_t v);
		return RES_W'(v);
	endfunction

	function automatic res_t times4(smp_t v);
		return sx(v) <<< 2;
	endfunction

endpackage

// ===== sv/five_point_laplacian_stencil_core.sv =====
// Five-point Laplacian stencil core: streamed square grid in, stencil results out.
// Depends on lap5_pkg and lap5_row_store.
//
//  channel | dir | handshake          | contents
//  --------+-----+--------------------+------------------------------------------
//  cfg     | in  | cfg_wr_en          | cfg_wr_data = side (grid points per side)
//  s       | in  | s_tvalid/s_tready  | s_tdata = sample (Q8.24)
//  m       | out | m_tvalid/m_tready  | m_tdata = result, row, column; m_tlast = final
//
// Takes one word per cycle unless stage 1 stalls. A taken word is held in stage 1, then
// its results are registered in the output slots. Past column 0, words on the last row
// produce two or three results, so there the input waits while the output slots drain
// one word a cycle while m_tready is high. The row store has no reset; entries are only
// used after the current grid wrote them. A side write restarts the grid at row 0, column 0.
module five_point_laplacian_stencil_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [lap5_pkg::SIDE_W-1:0]        cfg_wr_data,  // side
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [lap5_pkg::SMP_W-1:0]         s_tdata,      // sample
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [lap5_pkg::OUT_TDATA_W-1:0]   m_tdata,      // result, row, column, pad
	output logic                               m_tlast       // final_res
);
	import lap5_pkg::*;

	logic [SIDE_W-1:0] side_q;
	logic [SIDE_W-1:0] n_eff;
	logic [SIDE_W-1:0] n_m1;
	idx_t              row_q, col_q;
	idx_t              r_in, c_in;
	logic [SIDE_W-1:0] col_nx, row_nx;
	logic              accept;

	logic              valid_s1;
	smp_t              x_s1;
	idx_t              row_s1, col_s1;
	logic              commit;

	pair_t             cur_q, row0_q, rd;
	smp_t              pm1_q, rec0_q, rec1_q;
	smp_t              p_c, o_c;
	logic              has_up, has_up2, has_l, has_l2, has_r, last_row, last_col;
	res_t              v1, v2, v3;
	logic [2:0]        mask_s1;
	slot_t             new_slot [3];

	slot_t             slot_q [3];
	logic [2:0]        mask_q;
	logic              out_free;
	logic              pop;
	slot_t             sel;
	ram_wr_t           wr;

	// clamp side into the legal range
	always_comb begin
		if (side_q < SIDE_W'(2)) begin
			n_eff = SIDE_W'(2);
		end else if (side_q > SIDE_W'(MAX_SIDE)) begin
			n_eff = SIDE_W'(MAX_SIDE);
		end else begin
			n_eff = side_q;
		end
	end
	assign n_m1 = n_eff - SIDE_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= SIDE_W'(SIDE_RESET);
		end else if (cfg_wr_en) begin
			side_q <= cfg_wr_data;
		end
	end

	// position of the incoming word
	always_comb begin
		if (({1'b0, row_q} >= n_eff) || ({1'b0, col_q} >= n_eff)) begin
			r_in = '0;
			c_in = '0;
		end else begin
			r_in = row_q;
			c_in = col_q;
		end
	end
	assign col_nx = {1'b0, c_in} + SIDE_W'(1);
	assign row_nx = {1'b0, r_in} + SIDE_W'(1);
	assign accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (cfg_wr_en) begin
			row_q <= '0;
			col_q <= '0;
		end else if (accept) begin
			if (col_nx >= n_eff) begin
				col_q <= '0;
				row_q <= (row_nx >= n_eff) ? '0 : row_nx[IDX_W-1:0];
			end else begin
				col_q <= col_nx[IDX_W-1:0];
				row_q <= r_in;
			end
		end
	end

	// stage 1: word with its right-hand row-store entry
	assign s_tready = !valid_s1 || commit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (commit) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1   <= smp_t'(s_tdata);
			row_s1 <= r_in;
			col_s1 <= c_in;
		end
	end

	assign wr.en   = commit;
	assign wr.addr = col_s1;
	assign wr.data = '{older: p_c, prev: x_s1};

	lap5_row_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.rd_en   (accept),
		.rd_addr (col_nx[IDX_W-1:0]),
		.rd_data (rd)
	);

	// column 0 has no earlier read to carry it, so keep its entry in flops
	assign p_c = (col_s1 == '0) ? row0_q.prev  : cur_q.prev;
	assign o_c = (col_s1 == '0) ? row0_q.older : cur_q.older;

	assign has_up   = (row_s1 != '0);
	assign has_up2  = (row_s1 >= IDX_W'(2));
	assign has_l    = (col_s1 != '0);
	assign has_l2   = (col_s1 >= IDX_W'(2));
	assign has_r    = (({1'b0, col_s1} + SIDE_W'(1)) < n_eff);
	assign last_row = ({1'b0, row_s1} == n_m1);
	assign last_col = ({1'b0, col_s1} == n_m1);

	always_comb begin
		v1 = times4(p_c) - sx(x_s1)
			- (has_up2 ? sx(o_c)     : res_t'(0))
			- (has_l   ? sx(pm1_q)   : res_t'(0))
			- (has_r   ? sx(rd.prev) : res_t'(0));
		v2 = times4(rec0_q) - sx(x_s1) - sx(pm1_q)
			- (has_l2 ? sx(rec1_q) : res_t'(0));
		v3 = times4(x_s1) - sx(p_c) - sx(rec0_q);
	end

	assign mask_s1 = {last_row && last_col, last_row && has_l, has_up};

	assign new_slot[0] = '{fin: 1'b0, column: col_s1, row: row_s1 - IDX_W'(1), result: v1};
	assign new_slot[1] = '{fin: 1'b0, column: col_s1 - IDX_W'(1), row: row_s1, result: v2};
	assign new_slot[2] = '{fin: 1'b1, column: col_s1, row: row_s1, result: v3};

	// slots take a new set once empty or while their last word leaves
	assign out_free = ((mask_q & (mask_q - 3'd1)) == 3'd0) && ((mask_q == 3'd0) || m_tready);
	assign commit   = valid_s1 && ((mask_s1 == 3'd0) || out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec0_q <= '0;
			rec1_q <= '0;
		end else if (commit) begin
			rec1_q <= rec0_q;
			rec0_q <= x_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			cur_q <= rd;
			pm1_q <= p_c;
			if (col_s1 == '0) begin
				row0_q <= '{older: p_c, prev: x_s1};
			end
		end
	end

	// stage 2: up to three result slots, drained lowest first
	assign m_tvalid = (mask_q != 3'd0);
	assign pop      = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= 3'd0;
		end else if (commit && (mask_s1 != 3'd0)) begin
			mask_q <= mask_s1;
		end else if (pop) begin
			mask_q <= mask_q & (mask_q - 3'd1);
		end
	end

	always_ff @(posedge clk) begin
		if (commit && (mask_s1 != 3'd0)) begin
			slot_q[0] <= new_slot[0];
			slot_q[1] <= new_slot[1];
			slot_q[2] <= new_slot[2];
		end
	end

	always_comb begin
		if (mask_q[0]) begin
			sel = slot_q[0];
		end else if (mask_q[1]) begin
			sel = slot_q[1];
		end else begin
			sel = slot_q[2];
		end
	end

	assign m_tdata = {{OUT_PAD_W{1'b0}}, sel.column, sel.row, sel.result};
	assign m_tlast = sel.fin;

endmodule

// ===== sv/lap5_row_store.sv =====
// Row store: one synchronous memory holding the two most recent grid rows per column.
// Registered read with forwarding of a write to the same entry in the same cycle.
// Depends on lap5_pkg.
module lap5_row_store (
	input  logic              clk,
	input  logic              arst_n,
	input  lap5_pkg::ram_wr_t wr,
	input  logic              rd_en,
	input  lap5_pkg::idx_t    rd_addr,
	output lap5_pkg::pair_t   rd_data
);
	import lap5_pkg::*;

	pair_t mem [MAX_SIDE];
	pair_t ram_q;
	pair_t fwd_data_q;
	logic  fwd_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			ram_q <= mem[rd_addr];
		end
		if (rd_en && wr.en && (wr.addr == rd_addr)) begin
			fwd_data_q <= wr.data;
		end
	end

	// remember whether the last read collided with a write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (rd_en) begin
			fwd_q <= wr.en && (wr.addr == rd_addr);
		end
	end

	assign rd_data = fwd_q ? fwd_data_q : ram_q;

endmodule
